@@ hdl/assert_macros.svh @@
// Assertion helpers, clocked on aclk and disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define PIP_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

`define PIP_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define PIP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/pip_pkg.sv @@
`default_nettype none
package pip_pkg;

    localparam int EDGE_INDEX_W = 10;
    localparam int DIR_W        = 18;
    localparam int EPS_W        = 16;
    localparam int ECNT_W       = 11;
    localparam int ONE_Q        = 65536;
    localparam int OUT_TDATA_W  = 8;

    localparam logic REG_EPSILON    = 1'b0;
    localparam logic REG_EDGE_COUNT = 1'b1;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_DET_A,
        S_DET_B,
        S_TNUM_A,
        S_TNUM_B,
        S_TDIV,
        S_SNUM_A,
        S_SNUM_B,
        S_SDIV,
        S_COL_S,
        S_COL_T,
        S_EVAL,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

@@ hdl/point_in_polygon_parity.sv @@
// Load request: taken while idle and written to the edge memory at acceptance if its index is below MAX_EDGES.
// Query request: walks the stored edges in turn; each noncollinear edge takes six products
// and two quotients, a collinear one two products and one or two quotients, from the shared
// bit-serial multiplier and divider.
// One request in flight; the next is taken while a result waits at the output.
// aresetn (synchronous) clears control, epsilon to 1, edge count to 0; edge memory kept.
`default_nettype none
module point_in_polygon_parity
    import pip_pkg::*;
#(
    parameter int MAX_EDGES   = 1024,
    parameter int COORD_WIDTH = 32
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  cfg_we,
    input  wire                  cfg_index,
    input  wire  [EPS_W-1:0]     cfg_wdata,
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    // edge_index, start_x, start_y, end_x, end_y, query_x, query_y, dir_x, dir_y
    input  wire  [((EDGE_INDEX_W + 6*COORD_WIDTH + 2*DIR_W + 7)/8)*8-1:0] s_axis_tdata,
    // kind
    input  wire                  s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    // inside_res, on_boundary, degenerate
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int CW   = COORD_WIDTH;
    localparam int AW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CNTW = $clog2(MAX_EDGES + 1);
    localparam int IXW  = (AW > EDGE_INDEX_W) ? AW : EDGE_INDEX_W;
    localparam int MW   = (CW + 1 > DIR_W) ? CW + 1 : DIR_W;
    localparam int PW   = 2 * MW;
    localparam int DW   = PW + 1;
    localparam int WW   = DW + 16;
    localparam int QW   = CW + 1;
    localparam int KW   = $clog2(WW + 1);
    localparam int CMPW = CW + 19;
    localparam int OFF  = EDGE_INDEX_W;

    // ---- input unpack
    logic [EDGE_INDEX_W-1:0] in_idx;
    logic signed [CW-1:0]    in_sx, in_sy, in_ex, in_ey, in_qx, in_qy;
    logic signed [DIR_W-1:0] in_dx, in_dy;
    logic [IXW-1:0]          in_idx_w;
    logic                    in_acc, wr_en;

    assign in_idx   = s_axis_tdata[EDGE_INDEX_W-1:0];
    assign in_sx    = s_axis_tdata[OFF +: CW];
    assign in_sy    = s_axis_tdata[OFF + CW +: CW];
    assign in_ex    = s_axis_tdata[OFF + 2*CW +: CW];
    assign in_ey    = s_axis_tdata[OFF + 3*CW +: CW];
    assign in_qx    = s_axis_tdata[OFF + 4*CW +: CW];
    assign in_qy    = s_axis_tdata[OFF + 5*CW +: CW];
    assign in_dx    = s_axis_tdata[OFF + 6*CW +: DIR_W];
    assign in_dy    = s_axis_tdata[OFF + 6*CW + DIR_W +: DIR_W];
    assign in_idx_w = IXW'(in_idx);
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign wr_en    = in_acc && (s_axis_tuser == KIND_LOAD) && (32'(in_idx) < MAX_EDGES);

    // ---- registers
    state_t state_reg, state_next;
    logic [EPS_W-1:0]  eps_reg, eps_next;
    logic [ECNT_W-1:0] ec_reg, ec_next;
    logic [CNTW-1:0]   n_reg, n_next, idx_reg, idx_next;
    logic              par_reg, par_next;
    logic              run_reg, run_next;
    logic              m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;
    logic              res_in_reg, res_in_next, res_bnd_reg, res_bnd_next;
    logic              res_deg_reg, res_deg_next;
    logic signed [CW-1:0]    qx_reg, qx_next, qy_reg, qy_next;
    logic signed [DIR_W-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic signed [PW-1:0]    p_reg, p_next;
    logic signed [DW-1:0]    det_reg, det_next;
    logic signed [WW-1:0]    num_reg, num_next;
    logic signed [CW-1:0]    t_reg, t_next, s_reg, s_next;
    logic [KW-1:0]     cnt_reg, cnt_next;
    logic [MW-1:0]     mu_a_reg, mu_a_next;
    logic [2*MW:0]     mu_p_reg, mu_p_next;
    logic              mu_neg_reg, mu_neg_next;
    logic [WW-1:0]     dv_n_reg, dv_n_next, dv_d_reg, dv_d_next, dv_r_reg, dv_r_next;
    logic [QW-1:0]     dv_q_reg, dv_q_next;
    logic              dv_sat_reg, dv_sat_next, dv_neg_reg, dv_neg_next;

    // ---- edge memory
    logic [4*CW-1:0] mem [MAX_EDGES];
    logic [4*CW-1:0] mem_q;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[in_idx_w[AW-1:0]] <= {in_ey, in_ex, in_sy, in_sx};
        end
        if (state_reg == S_READ) begin
            mem_q <= mem[idx_reg[AW-1:0]];
        end
    end

    logic signed [CW-1:0] e_sx, e_sy, e_ex, e_ey;
    logic signed [MW-1:0] a01, a11, s0, s1, dx_m, dy_m;

    assign e_sx = mem_q[CW-1:0];
    assign e_sy = mem_q[2*CW-1:CW];
    assign e_ex = mem_q[3*CW-1:2*CW];
    assign e_ey = mem_q[4*CW-1:3*CW];
    assign a01  = MW'(e_ex) - MW'(e_sx);
    assign a11  = MW'(e_ey) - MW'(e_sy);
    assign s0   = MW'(e_ex) - MW'(qx_reg);
    assign s1   = MW'(e_ey) - MW'(qy_reg);
    assign dx_m = MW'(dx_reg);
    assign dy_m = MW'(dy_reg);

    // ---- helpers
    function automatic logic in_rng(input logic signed [CW-1:0] v,
                                    input logic [EPS_W-1:0] e);
        logic signed [CMPW-1:0] vw, ew, oq;
        vw = CMPW'(v);
        ew = $signed(CMPW'(e));
        oq = CMPW'(ONE_Q);
        return (vw > -ew) && (vw < oq + ew);
    endfunction

    function automatic logic t_small(input logic signed [CW-1:0] v,
                                     input logic [EPS_W-1:0] e);
        logic signed [CMPW-1:0] vw, ew;
        vw = CMPW'(v);
        ew = $signed(CMPW'(e));
        return (vw <= ew) && (vw >= -ew);
    endfunction

    // ---- multiplier datapath
    logic signed [MW-1:0] mul_a, mul_b;
    logic [MW-1:0]        mul_ua, mul_ub;
    logic [MW:0]          mu_sum;
    logic [2*MW:0]        mu_shift;
    logic [PW-1:0]        mu_mag;
    logic signed [PW-1:0] mul_res;

    always_comb begin
        case (state_reg)
            S_DET_A:  begin mul_a = dx_m; mul_b = a11;  end
            S_DET_B:  begin mul_a = a01;  mul_b = dy_m; end
            S_TNUM_A: begin mul_a = a11;  mul_b = s0;   end
            S_TNUM_B: begin mul_a = a01;  mul_b = s1;   end
            S_SNUM_A: begin mul_a = dx_m; mul_b = s1;   end
            S_SNUM_B: begin mul_a = dy_m; mul_b = s0;   end
            default:  begin mul_a = '0;   mul_b = '0;   end
        endcase
    end

    assign mul_ua   = mul_a[MW-1] ? (~mul_a + 1'b1) : mul_a;
    assign mul_ub   = mul_b[MW-1] ? (~mul_b + 1'b1) : mul_b;
    assign mu_sum   = mu_p_reg[2*MW:MW] + (mu_p_reg[0] ? {1'b0, mu_a_reg} : '0);
    assign mu_shift = {mu_sum, mu_p_reg[MW-1:0]} >> 1;
    assign mu_mag   = mu_shift[PW-1:0];
    assign mul_res  = mu_neg_reg ? -$signed(mu_mag) : $signed(mu_mag);

    // ---- divider datapath
    logic signed [WW-1:0] div_n, div_d;
    logic [WW-1:0]        div_un, div_ud;
    logic [WW:0]          dv_r2;
    logic                 dv_ge, dv_big;
    logic [WW:0]          dv_rs;
    logic [QW-1:0]        dv_qn, dv_mag, dv_val;
    logic                 dv_satn;
    logic signed [CW-1:0] div_res;
    logic                 a01_gt, dx_gt;
    logic [QW-1:0]        lim;

    assign a01_gt = !a01[MW-1] && ($unsigned(a01) > MW'(eps_reg));
    assign dx_gt  = !dx_reg[DIR_W-1] && ($unsigned(dx_reg) > DIR_W'(eps_reg));

    always_comb begin
        case (state_reg)
            S_TDIV, S_SDIV: begin
                div_n = num_reg;
                div_d = WW'(det_reg);
            end
            S_COL_S: begin
                div_n = a01_gt ? (WW'(s0) <<< 16) : (WW'(s1) <<< 16);
                div_d = a01_gt ? WW'(a01) : WW'(a11);
            end
            S_COL_T: begin
                div_n = dx_gt ? (WW'(s0) <<< 16) : (WW'(s1) <<< 16);
                div_d = dx_gt ? WW'(dx_reg) : WW'(dy_reg);
            end
            default: begin
                div_n = '0;
                div_d = '0;
            end
        endcase
    end

    assign lim     = QW'(1) << (CW - 1);
    assign div_un  = div_n[WW-1] ? (~div_n + 1'b1) : div_n;
    assign div_ud  = div_d[WW-1] ? (~div_d + 1'b1) : div_d;
    assign dv_r2   = {dv_r_reg, dv_n_reg[WW-1]};
    assign dv_ge   = dv_r2 >= {1'b0, dv_d_reg};
    assign dv_rs   = dv_ge ? (dv_r2 - {1'b0, dv_d_reg}) : dv_r2;
    assign dv_qn   = {dv_q_reg[QW-2:0], dv_ge};
    assign dv_satn = dv_sat_reg | dv_q_reg[QW-1];
    assign dv_big  = dv_satn || (dv_qn > lim);

    always_comb begin
        if (dv_neg_reg) begin
            dv_mag = dv_big ? lim : dv_qn;
            dv_val = ~dv_mag + 1'b1;
        end else begin
            dv_mag = (dv_big || dv_qn >= lim) ? (lim - 1'b1) : dv_qn;
            dv_val = dv_mag;
        end
    end
    assign div_res = dv_val[CW-1:0];

    // ---- determinant and numerator differences
    logic signed [DW-1:0] diff_new;
    logic [DW-1:0]        det_abs, eps_sh;

    assign diff_new = DW'(p_reg) - DW'(mul_res);
    assign det_abs  = diff_new[DW-1] ? -diff_new : diff_new;
    assign eps_sh   = DW'({eps_reg, 16'h0000});

    // ---- evaluation of one edge
    logic t_pos, s_rng, t_bnd, last_edge;
    logic [CNTW-1:0] n_sel;

    assign t_pos     = !t_reg[CW-1] && (t_reg != '0);
    assign s_rng     = in_rng(s_reg, eps_reg);
    assign t_bnd     = t_small(t_reg, eps_reg);
    assign last_edge = (idx_reg + 1'b1) == n_reg;
    assign n_sel     = (32'(ec_reg) < MAX_EDGES) ? CNTW'(ec_reg) : CNTW'(MAX_EDGES);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // ---- next state
    always_comb begin
        logic mul_done, div_done;
        state_next   = state_reg;
        eps_next     = eps_reg;
        ec_next      = ec_reg;
        n_next       = n_reg;
        idx_next     = idx_reg;
        par_next     = par_reg;
        run_next     = run_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        res_in_next  = res_in_reg;
        res_bnd_next = res_bnd_reg;
        res_deg_next = res_deg_reg;
        qx_next      = qx_reg;
        qy_next      = qy_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        p_next       = p_reg;
        det_next     = det_reg;
        num_next     = num_reg;
        t_next       = t_reg;
        s_next       = s_reg;
        cnt_next     = cnt_reg;
        mu_a_next    = mu_a_reg;
        mu_p_next    = mu_p_reg;
        mu_neg_next  = mu_neg_reg;
        dv_n_next    = dv_n_reg;
        dv_d_next    = dv_d_reg;
        dv_r_next    = dv_r_reg;
        dv_q_next    = dv_q_reg;
        dv_sat_next  = dv_sat_reg;
        dv_neg_next  = dv_neg_reg;
        mul_done     = 1'b0;
        div_done     = 1'b0;

        if (cfg_we) begin
            case (cfg_index)
                REG_EPSILON:    eps_next = cfg_wdata;
                REG_EDGE_COUNT: ec_next  = cfg_wdata[ECNT_W-1:0];
                default: ;
            endcase
        end

        // shared multiplier and divider
        case (state_reg)
            S_DET_A, S_DET_B, S_TNUM_A, S_TNUM_B, S_SNUM_A, S_SNUM_B: begin
                if (!run_reg) begin
                    mu_a_next   = mul_ua;
                    mu_p_next   = {{(MW+1){1'b0}}, mul_ub};
                    mu_neg_next = mul_a[MW-1] ^ mul_b[MW-1];
                    cnt_next    = '0;
                    run_next    = 1'b1;
                end else begin
                    mu_p_next = mu_shift;
                    cnt_next  = cnt_reg + 1'b1;
                    if (cnt_reg == KW'(MW - 1)) begin
                        run_next = 1'b0;
                        mul_done = 1'b1;
                    end
                end
            end
            S_TDIV, S_SDIV, S_COL_S, S_COL_T: begin
                if (!run_reg) begin
                    dv_n_next   = div_un;
                    dv_d_next   = div_ud;
                    dv_r_next   = '0;
                    dv_q_next   = '0;
                    dv_sat_next = 1'b0;
                    dv_neg_next = div_n[WW-1] ^ div_d[WW-1];
                    cnt_next    = '0;
                    run_next    = 1'b1;
                end else begin
                    dv_n_next   = dv_n_reg << 1;
                    dv_r_next   = dv_rs[WW-1:0];
                    dv_q_next   = dv_qn;
                    dv_sat_next = dv_satn;
                    cnt_next    = cnt_reg + 1'b1;
                    if (cnt_reg == KW'(WW - 1)) begin
                        run_next = 1'b0;
                        div_done = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        case (state_reg)
            S_IDLE: begin
                if (in_acc && s_axis_tuser == KIND_QUERY) begin
                    qx_next      = in_qx;
                    qy_next      = in_qy;
                    dx_next      = in_dx;
                    dy_next      = in_dy;
                    n_next       = n_sel;
                    idx_next     = '0;
                    par_next     = 1'b0;
                    run_next     = 1'b0;
                    res_in_next  = 1'b0;
                    res_bnd_next = 1'b0;
                    res_deg_next = 1'b0;
                    state_next   = (n_sel == '0) ? S_DONE : S_READ;
                end
            end
            S_READ:  state_next = S_DET_A;
            S_DET_A: begin
                if (mul_done) begin
                    p_next     = mul_res;
                    state_next = S_DET_B;
                end
            end
            S_DET_B: begin
                if (mul_done) begin
                    det_next   = diff_new;
                    state_next = (det_abs > eps_sh) ? S_TNUM_A : S_COL_S;
                end
            end
            S_TNUM_A: begin
                if (mul_done) begin
                    p_next     = mul_res;
                    state_next = S_TNUM_B;
                end
            end
            S_TNUM_B: begin
                if (mul_done) begin
                    num_next   = WW'(diff_new) <<< 16;
                    state_next = S_TDIV;
                end
            end
            S_TDIV: begin
                if (div_done) begin
                    t_next     = div_res;
                    state_next = S_SNUM_A;
                end
            end
            S_SNUM_A: begin
                if (mul_done) begin
                    p_next     = mul_res;
                    state_next = S_SNUM_B;
                end
            end
            S_SNUM_B: begin
                if (mul_done) begin
                    num_next   = WW'(diff_new) <<< 16;
                    state_next = S_SDIV;
                end
            end
            S_SDIV: begin
                if (div_done) begin
                    s_next     = div_res;
                    state_next = S_EVAL;
                end
            end
            S_COL_S: begin
                if (div_done) begin
                    if (in_rng(div_res, eps_reg)) begin
                        s_next     = div_res;
                        t_next     = '0;
                        state_next = S_EVAL;
                    end else begin
                        s_next     = '0;
                        state_next = S_COL_T;
                    end
                end
            end
            S_COL_T: begin
                if (div_done) begin
                    t_next     = div_res;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                if (s_reg == '0 && t_pos) begin
                    res_deg_next = 1'b1;
                    state_next   = S_DONE;
                end else if (s_rng && t_bnd) begin
                    res_in_next  = 1'b1;
                    res_bnd_next = 1'b1;
                    state_next   = S_DONE;
                end else begin
                    par_next = par_reg ^ (s_rng && t_pos);
                    if (last_edge) begin
                        res_in_next = par_reg ^ (s_rng && t_pos);
                        state_next  = S_DONE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = OUT_TDATA_W'({res_deg_reg, res_bnd_reg, res_in_reg});
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            eps_reg     <= EPS_W'(1);
            ec_reg      <= '0;
            run_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            eps_reg     <= eps_next;
            ec_reg      <= ec_next;
            run_reg     <= run_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        idx_reg     <= idx_next;
        par_reg     <= par_next;
        m_data_reg  <= m_data_next;
        res_in_reg  <= res_in_next;
        res_bnd_reg <= res_bnd_next;
        res_deg_reg <= res_deg_next;
        qx_reg      <= qx_next;
        qy_reg      <= qy_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        p_reg       <= p_next;
        det_reg     <= det_next;
        num_reg     <= num_next;
        t_reg       <= t_next;
        s_reg       <= s_next;
        cnt_reg     <= cnt_next;
        mu_a_reg    <= mu_a_next;
        mu_p_reg    <= mu_p_next;
        mu_neg_reg  <= mu_neg_next;
        dv_n_reg    <= dv_n_next;
        dv_d_reg    <= dv_d_next;
        dv_r_reg    <= dv_r_next;
        dv_q_reg    <= dv_q_next;
        dv_sat_reg  <= dv_sat_next;
        dv_neg_reg  <= dv_neg_next;
    end

`include "assert_macros.svh"

    `PIP_ASSERT_IMPLY(a_idx_range, (state_reg != S_IDLE && state_reg != S_DONE), (idx_reg < n_reg), "edge index beyond walk length")
    `PIP_ASSERT_IMPLY(a_flags, (m_valid_reg && m_data_reg[1]), (m_data_reg[0] && !m_data_reg[2]), "boundary result malformed")
    `PIP_ASSERT_NEXT(a_done_hold, (state_reg == S_DONE && m_valid_reg && !m_axis_tready), (state_reg == S_DONE && m_valid_reg), "result overwritten while stalled")

endmodule
`default_nettype wire
